// ===== rtl/core/sparse_recurrent_net_tick_macros.svh =====
// Assertion macros shared by the sparse recurrent network tick engine.
`ifndef SPARSE_RECURRENT_NET_TICK_MACROS_SVH
`define SPARSE_RECURRENT_NET_TICK_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SRNT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sparse_recurrent_net_tick: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define SRNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sparse_recurrent_net_tick: next-cycle check failed");

`endif

// ===== rtl/core/srnt_pkg.sv =====
// Types, codes and the logistic table of the sparse recurrent network tick engine.
package srnt_pkg;

    localparam int DEF_MAX_NEURONS     = 64;
    localparam int DEF_MAX_CONNECTIONS = 256;
    localparam int DEF_MAX_OUTPUTS     = 16;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Operation codes
    localparam logic [1:0] OP_LOAD      = 2'd0;
    localparam logic [1:0] OP_SET_INPUT = 2'd1;
    localparam logic [1:0] OP_TICK      = 2'd2;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [1:0] REG_OUTPUT_COUNT = 2'd1;
    localparam logic [1:0] REG_CONN_COUNT   = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [7:0]         conn_index;
        logic [5:0]         src_neuron;
        logic [5:0]         dst_neuron;
        logic signed [15:0] value;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  out_index;
        logic [15:0] activation;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [5:0]         src_neuron;
        logic [5:0]         dst_neuron;
        logic signed [15:0] weight;
    } t_conn;

    // round(65536 * sigma(x)) at x = -8, -7.5, ..., 8
    function automatic logic [15:0] sig_point(input logic [5:0] idx);
        logic [15:0] v;
        case (idx)
            6'd0:  v = 16'd22;
            6'd1:  v = 16'd36;
            6'd2:  v = 16'd60;
            6'd3:  v = 16'd98;
            6'd4:  v = 16'd162;
            6'd5:  v = 16'd267;
            6'd6:  v = 16'd439;
            6'd7:  v = 16'd720;
            6'd8:  v = 16'd1179;
            6'd9:  v = 16'd1921;
            6'd10: v = 16'd3108;
            6'd11: v = 16'd4971;
            6'd12: v = 16'd7812;
            6'd13: v = 16'd11955;
            6'd14: v = 16'd17625;
            6'd15: v = 16'd24743;
            6'd16: v = 16'd32768;
            6'd17: v = 16'd40793;
            6'd18: v = 16'd47911;
            6'd19: v = 16'd53581;
            6'd20: v = 16'd57724;
            6'd21: v = 16'd60565;
            6'd22: v = 16'd62428;
            6'd23: v = 16'd63615;
            6'd24: v = 16'd64357;
            6'd25: v = 16'd64816;
            6'd26: v = 16'd65097;
            6'd27: v = 16'd65269;
            6'd28: v = 16'd65374;
            6'd29: v = 16'd65438;
            6'd30: v = 16'd65476;
            6'd31: v = 16'd65500;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/sparse_recurrent_net_tick.sv =====
// Top level of the sparse recurrent network tick engine.
//
//  channel   signals                           direction  transfer when
//  command   start, busy, i_cmd                in         start && !busy
//  result    o_strobe, o_res                   out        o_strobe (one cycle, no stall)
//  config    psel penable pwrite paddr pwdata  in         psel && penable && pwrite && pready
//
// Load and set-input commands finish at the edge that accepts them; busy stays low.
// A tick runs three walks in turn: the connection walk streams one table entry per
// cycle through the sum memory's single read-modify-write port, then the neuron walk
// streams every neuron through the logistic unit, then outputs are read from the
// activation memory one per cycle.
// After reset the block clears both neuron memories with busy high.
// Results cannot be stalled by the receiver; each is shown for exactly one cycle.
`include "sparse_recurrent_net_tick_macros.svh"

module sparse_recurrent_net_tick
    import srnt_pkg::*;
#(
    parameter int MAX_NEURONS     = DEF_MAX_NEURONS,
    parameter int MAX_CONNECTIONS = DEF_MAX_CONNECTIONS,
    parameter int MAX_OUTPUTS     = DEF_MAX_OUTPUTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_cmd              i_cmd,
    output logic              o_strobe,
    output t_res              o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int NAW = $clog2(MAX_NEURONS);
    localparam int NKW = $clog2(MAX_NEURONS + 1);
    localparam int CAW = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
    localparam int CKW = $clog2(MAX_CONNECTIONS + 1);
    localparam int OKW = $clog2(MAX_OUTPUTS + 1);

    localparam logic [10:0] NEUR_LIMIT = 11'(MAX_NEURONS);
    localparam logic [16:0] CONN_LIMIT = 17'(MAX_CONNECTIONS);
    localparam logic [6:0]  OUT_LIMIT  = 7'(MAX_OUTPUTS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CONN,
        S_NEUR,
        S_OUT
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [5:0] r_input_count;
    logic [4:0] r_output_count;
    logic [8:0] r_conn_count;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count  <= '0;
            r_output_count <= '0;
            r_conn_count   <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_INPUT_COUNT:  r_input_count  <= pwdata[5:0];
                REG_OUTPUT_COUNT: r_output_count <= pwdata[4:0];
                REG_CONN_COUNT:   r_conn_count   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_INPUT_COUNT:  prdata = {26'd0, r_input_count};
            REG_OUTPUT_COUNT: prdata = {27'd0, r_output_count};
            REG_CONN_COUNT:   prdata = {23'd0, r_conn_count};
            default:          prdata = '0;
        endcase
    end

    // Clamp walk lengths to the table and output limits
    logic [CKW-1:0] conn_total;
    logic [OKW-1:0] out_total;

    always_comb begin
        if (17'(r_conn_count) > CONN_LIMIT) begin
            conn_total = CKW'(MAX_CONNECTIONS);
        end else begin
            conn_total = CKW'(r_conn_count);
        end
        if (7'(r_output_count) > OUT_LIMIT) begin
            out_total = OKW'(MAX_OUTPUTS);
        end else begin
            out_total = OKW'(r_output_count);
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    t_state         r_state;
    logic [NKW-1:0] r_n;
    logic [CKW-1:0] r_k;
    logic [OKW-1:0] r_o;
    logic           r_c1_vld;
    logic           r_c2_vld;
    logic           r_c3_vld;
    logic           r_wb_vld;
    logic           r_l1_vld;
    logic           r_p1_vld;
    logic           r_strobe;

    logic accept;
    logic conn_issue;
    logic neur_issue;
    logic out_issue;
    logic conn_done;
    logic neur_done;
    logic out_done;

    // ------------------------------------------------------------------
    // Payload pipeline registers
    // ------------------------------------------------------------------
    t_conn              r_conn_q;
    logic [15:0]        r_act_q;
    logic signed [31:0] r_sum_q;
    logic [NAW-1:0]     r_c2_dst;
    logic signed [15:0] r_c2_w;
    logic [NAW-1:0]     r_c3_dst;
    logic signed [32:0] r_c3_p;
    logic [NAW-1:0]     r_wb_dst;
    logic signed [31:0] r_wb_sum;
    logic [NAW-1:0]     r_l1_n;
    logic [OKW-1:0]     r_p1_k;
    logic               r_p1_ok;
    logic               r_p1_last;
    t_res               r_res;

    // Logistic unit results
    logic           lgs_vld;
    logic [NAW-1:0] lgs_tag;
    logic [15:0]    lgs_act;
    logic           lgs_pending;

    assign busy   = (r_state != S_IDLE);
    assign accept = start & ~busy;

    // ------------------------------------------------------------------
    // Connection walk datapath
    // ------------------------------------------------------------------
    logic               c1_ok;
    logic signed [16:0] c3_q;
    logic signed [31:0] c3_base;
    logic [32:0]        c3_wide;
    logic signed [31:0] c3_sum;

    assign c1_ok = r_c1_vld
                 && (11'(r_conn_q.src_neuron) < NEUR_LIMIT)
                 && (11'(r_conn_q.dst_neuron) < NEUR_LIMIT);

    always_comb begin
        // floor(product / 65536)
        c3_q = r_c3_p[32:16];
        // forward the sum written at the edge where this entry was read
        if (r_wb_vld && (r_wb_dst == r_c3_dst)) begin
            c3_base = r_wb_sum;
        end else begin
            c3_base = r_sum_q;
        end
        c3_wide = {c3_base[31], c3_base} + {{16{c3_q[16]}}, c3_q};
        if (c3_wide[32] != c3_wide[31]) begin
            c3_sum = c3_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            c3_sum = c3_wide[31:0];
        end
    end

    // ------------------------------------------------------------------
    // Output walk
    // ------------------------------------------------------------------
    logic [6:0] out_id;
    logic       out_ok;
    logic       out_last;

    always_comb begin
        out_id   = 7'(r_input_count) + 7'(r_o);
        out_ok   = (11'(out_id) < NEUR_LIMIT);
        out_last = (({1'b0, r_o} + 1'b1) == {1'b0, out_total});
    end

    // ------------------------------------------------------------------
    // Issue and completion
    // ------------------------------------------------------------------
    assign conn_issue = (r_state == S_CONN) && (r_k < conn_total);
    assign neur_issue = (r_state == S_NEUR) && (r_n < NKW'(MAX_NEURONS));
    assign out_issue  = (r_state == S_OUT) && (r_o < out_total);
    assign conn_done  = (r_k == conn_total) && !r_c1_vld && !r_c2_vld && !r_c3_vld;
    assign neur_done  = (r_n == NKW'(MAX_NEURONS)) && !r_l1_vld && !lgs_pending;
    assign out_done   = (r_o == out_total) && !r_p1_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_n      <= '0;
            r_k      <= '0;
            r_o      <= '0;
            r_c1_vld <= 1'b0;
            r_c2_vld <= 1'b0;
            r_c3_vld <= 1'b0;
            r_wb_vld <= 1'b0;
            r_l1_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_c1_vld <= conn_issue;
            r_c2_vld <= c1_ok;
            r_c3_vld <= r_c2_vld;
            r_wb_vld <= r_c3_vld;
            r_l1_vld <= neur_issue;
            r_p1_vld <= out_issue;
            r_strobe <= r_p1_vld;
            if (conn_issue) begin
                r_k <= r_k + 1'b1;
            end
            if (neur_issue || (r_state == S_CLEAR)) begin
                r_n <= r_n + 1'b1;
            end
            if (out_issue) begin
                r_o <= r_o + 1'b1;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_n == NKW'(MAX_NEURONS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && (i_cmd.op == OP_TICK)) begin
                        r_state <= S_CONN;
                        r_k     <= '0;
                    end
                end
                S_CONN: begin
                    if (conn_done) begin
                        r_state <= S_NEUR;
                        r_n     <= '0;
                    end
                end
                S_NEUR: begin
                    if (neur_done) begin
                        r_state <= S_OUT;
                        r_o     <= '0;
                    end
                end
                S_OUT: begin
                    if (out_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_c2_dst  <= NAW'(r_conn_q.dst_neuron);
        r_c2_w    <= r_conn_q.weight;
        r_c3_dst  <= r_c2_dst;
        r_c3_p    <= $signed({1'b0, r_act_q}) * r_c2_w;
        r_wb_dst  <= r_c3_dst;
        r_wb_sum  <= c3_sum;
        r_l1_n    <= r_n[NAW-1:0];
        r_p1_k    <= r_o;
        r_p1_ok   <= out_ok;
        r_p1_last <= out_last;
        r_res.out_index  <= 4'(r_p1_k);
        r_res.activation <= r_p1_ok ? r_act_q : 16'd0;
        r_res.last       <= r_p1_last;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    // ------------------------------------------------------------------
    // Connection table: written by load, walked by tick
    // ------------------------------------------------------------------
    t_conn          conn_mem [MAX_CONNECTIONS];
    logic           conn_we;
    logic [CAW-1:0] conn_waddr;
    t_conn          conn_wdata;

    always_comb begin
        conn_we    = accept && (i_cmd.op == OP_LOAD) && (17'(i_cmd.conn_index) < CONN_LIMIT);
        conn_waddr = CAW'(i_cmd.conn_index);
        conn_wdata.src_neuron = i_cmd.src_neuron;
        conn_wdata.dst_neuron = i_cmd.dst_neuron;
        conn_wdata.weight     = i_cmd.value;
    end

    always_ff @(posedge i_clk) begin
        if (conn_we) begin
            conn_mem[conn_waddr] <= conn_wdata;
        end
        r_conn_q <= conn_mem[r_k[CAW-1:0]];
    end

    // ------------------------------------------------------------------
    // Activation memory
    // ------------------------------------------------------------------
    logic [15:0]    act_mem [MAX_NEURONS];
    logic           act_we;
    logic [NAW-1:0] act_waddr;
    logic [15:0]    act_wdata;
    logic [NAW-1:0] act_raddr;

    always_comb begin
        if (r_state == S_CLEAR) begin
            act_we    = 1'b1;
            act_waddr = r_n[NAW-1:0];
            act_wdata = '0;
        end else begin
            act_we    = lgs_vld;
            act_waddr = lgs_tag;
            act_wdata = lgs_act;
        end
        if (r_state == S_OUT) begin
            act_raddr = NAW'(out_id);
        end else begin
            act_raddr = NAW'(r_conn_q.src_neuron);
        end
    end

    always_ff @(posedge i_clk) begin
        if (act_we) begin
            act_mem[act_waddr] <= act_wdata;
        end
        r_act_q <= act_mem[act_raddr];
    end

    // ------------------------------------------------------------------
    // Sum memory: cleared after reset, set input, accumulate, clear during the neuron walk
    // ------------------------------------------------------------------
    logic signed [31:0] sum_mem [MAX_NEURONS];
    logic               sum_we;
    logic [NAW-1:0]     sum_waddr;
    logic signed [31:0] sum_wdata;
    logic [NAW-1:0]     sum_raddr;

    always_comb begin
        sum_we    = 1'b0;
        sum_waddr = r_n[NAW-1:0];
        sum_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                sum_we = 1'b1;
            end
            S_IDLE: begin
                sum_we    = accept && (i_cmd.op == OP_SET_INPUT)
                          && (i_cmd.src_neuron < r_input_count)
                          && (11'(i_cmd.src_neuron) < NEUR_LIMIT);
                sum_waddr = NAW'(i_cmd.src_neuron);
                sum_wdata = {{16{i_cmd.value[15]}}, i_cmd.value};
            end
            S_CONN: begin
                sum_we    = r_c3_vld;
                sum_waddr = r_c3_dst;
                sum_wdata = c3_sum;
            end
            S_NEUR: begin
                // read-first: the old sum goes to the logistic unit
                sum_we = neur_issue;
            end
            default: sum_we = 1'b0;
        endcase
        if (r_state == S_NEUR) begin
            sum_raddr = r_n[NAW-1:0];
        end else begin
            sum_raddr = r_c2_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        r_sum_q <= sum_mem[sum_raddr];
    end

    // ------------------------------------------------------------------
    // Logistic unit
    // ------------------------------------------------------------------
    srnt_logistic #(
        .MAX_NEURONS (MAX_NEURONS)
    ) u_logistic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (r_l1_vld),
        .i_tag     (r_l1_n),
        .i_sum     (r_sum_q),
        .o_vld     (lgs_vld),
        .o_tag     (lgs_tag),
        .o_act     (lgs_act),
        .o_pending (lgs_pending)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SRNT_ASSERT_IMPLY(a_strobe_from_out, i_clk, i_rst_n, o_strobe, $past(r_state) == S_OUT)
    `SRNT_ASSERT_IMPLY(a_accum_in_conn, i_clk, i_rst_n, r_c3_vld, r_state == S_CONN)
    `SRNT_ASSERT_NEXT(a_tick_goes_busy, i_clk, i_rst_n, accept && (i_cmd.op == OP_TICK), busy)
    `SRNT_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, o_strobe && o_res.last, !o_strobe)

endmodule

// ===== rtl/core/srnt_logistic.sv =====
// Two-stage logistic unit: saturate and look up, then interpolate.
module srnt_logistic
    import srnt_pkg::*;
#(
    parameter int MAX_NEURONS = DEF_MAX_NEURONS,
    localparam int NAW = $clog2(MAX_NEURONS)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [NAW-1:0]     i_tag,
    input  logic signed [31:0] i_sum,
    output logic               o_vld,
    output logic [NAW-1:0]     o_tag,
    output logic [15:0]        o_act,
    output logic               o_pending
);

    logic [15:0]    clip;
    logic [15:0]    u;
    logic [5:0]     seg;
    logic           r_vld_a;
    logic           r_vld_b;
    logic [NAW-1:0] r_tag_a;
    logic [NAW-1:0] r_tag_b;
    logic [15:0]    r_t0;
    logic [15:0]    r_t1;
    logic [10:0]    r_f;
    logic [15:0]    r_act;
    logic [15:0]    diff;
    logic [26:0]    prod;

    // Clip to [-8, 8) in Q4.12 and rebase to unsigned
    always_comb begin
        if (i_sum > 32'sd32767) begin
            clip = 16'h7FFF;
        end else if (i_sum < -32'sd32768) begin
            clip = 16'h8000;
        end else begin
            clip = i_sum[15:0];
        end
        u   = {~clip[15], clip[14:0]};
        seg = {1'b0, u[15:11]};
    end

    always_comb begin
        diff = r_t1 - r_t0;
        prod = diff * r_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag_a <= i_tag;
        r_t0    <= sig_point(seg);
        r_t1    <= sig_point(seg + 6'd1);
        r_f     <= u[10:0];
        r_tag_b <= r_tag_a;
        r_act   <= r_t0 + prod[26:11];
    end

    assign o_vld     = r_vld_b;
    assign o_tag     = r_tag_b;
    assign o_act     = r_act;
    assign o_pending = r_vld_a | r_vld_b;

endmodule

// ===== test/tb_sparse_recurrent_net_tick.sv =====
// Self-checking testbench for the sparse recurrent network tick engine.
`timescale 1ns / 1ps

module tb_sparse_recurrent_net_tick;
    import srnt_pkg::*;

    // Op code with no function; the block must drop it without a result.
    localparam logic [1:0] OP_NONE   = 2'd3;
    // Register index past the end of the map; writes to it must change nothing.
    localparam logic [1:0] REG_SPARE = 2'd3;

    localparam int NEURONS = DEF_MAX_NEURONS;
    localparam int LINKS   = DEF_MAX_CONNECTIONS;
    localparam int OUTPUTS = DEF_MAX_OUTPUTS;

    // Longest tick is one walk over the links, one over the neurons, the output
    // reads and a short pipeline; allow some margin on top.
    localparam int SETTLE_CYCLES = LINKS + NEURONS + OUTPUTS + 64;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT   = 4000;

    localparam longint SUM_HI = 64'sh7FFF_FFFF;
    localparam longint SUM_LO = -64'sh8000_0000;

    typedef enum logic {ROW_CMD, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  reg_idx;
        logic [31:0] reg_data;
        t_cmd        cmd;
        int          typed_n;    // -1: let the predictor decide
        logic [15:0] typed_act;  // activation carried by every typed output
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        i_cmd;
    logic        o_strobe;
    t_res        o_res;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic        pready;

    // Mirror of the network state and registers.
    t_conn              link_tab [LINKS];
    logic [15:0]        net_act  [NEURONS];
    logic signed [31:0] net_sum  [NEURONS];
    logic [5:0]         in_cnt;
    logic [4:0]         out_cnt;
    logic [8:0]         conn_cnt;

    // Knee points of the logistic: round(65536 * sigma(x)), x = -8 .. 8 step 0.5.
    int sig_knee [33] = '{
        22, 36, 60, 98, 162, 267, 439, 720,
        1179, 1921, 3108, 4971, 7812, 11955, 17625, 24743,
        32768,
        40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
        64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
    };

    t_res owed_outputs [$];  // activations still to come out of the block, oldest first
    t_res tick_out [$];      // outputs produced by the latest predicted command
    int   mismatches = 0;
    bit   start_hot = 1'b0;  // start is currently driven high
    bit   steady = 1'b0;     // suppress sender gaps

    sparse_recurrent_net_tick DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_res    (o_res),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // Saturate to [-8, 8) in Q4.12 and interpolate between the two nearest knees.
    function automatic logic [15:0] logistic16(input logic signed [31:0] s);
        int c;
        int u;
        int i;
        int f;
        int d;
        c = s;
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        u = c + 32768;
        i = u >> 11;
        f = u & 2047;
        d = sig_knee[i + 1] - sig_knee[i];
        return 16'(sig_knee[i] + ((d * f) >> 11));
    endfunction

    // Advance the mirrored network by one accepted command; outputs land in tick_out.
    task automatic advance_net(input t_cmd c);
        int     k;
        int     lim;
        int     oc;
        int     id;
        longint prod;
        longint acc;
        t_conn  lk;
        t_res   r;
        tick_out.delete();
        case (c.op)
            OP_LOAD: begin
                link_tab[c.conn_index] = {c.src_neuron, c.dst_neuron, c.value};
            end
            OP_SET_INPUT: begin
                if (int'(c.src_neuron) < int'(in_cnt))
                    net_sum[c.src_neuron] = {{16{c.value[15]}}, c.value};
            end
            OP_TICK: begin
                // Accumulate with the activations from before this tick.
                lim = (int'(conn_cnt) > LINKS) ? LINKS : int'(conn_cnt);
                for (k = 0; k < lim; k++) begin
                    lk   = link_tab[k];
                    prod = longint'(net_act[lk.src_neuron]) * longint'(lk.weight);
                    // Q4.28 -> Q.12, floor toward minus infinity
                    acc  = longint'(net_sum[lk.dst_neuron]) + (prod >>> 16);
                    if (acc > SUM_HI) acc = SUM_HI;
                    if (acc < SUM_LO) acc = SUM_LO;
                    net_sum[lk.dst_neuron] = acc[31:0];
                end
                for (k = 0; k < NEURONS; k++) begin
                    net_act[k] = logistic16(net_sum[k]);
                    net_sum[k] = '0;
                end
                oc = (int'(out_cnt) > OUTPUTS) ? OUTPUTS : int'(out_cnt);
                for (k = 0; k < oc; k++) begin
                    id = int'(in_cnt) + k;
                    r.out_index  = 4'(k);
                    r.activation = (id < NEURONS) ? net_act[id] : 16'd0;
                    r.last       = (k == oc - 1);
                    tick_out.push_back(r);
                end
            end
            default: ;  // unused op: no state change, no output
        endcase
    endtask

    function automatic logic [31:0] reg_value(input logic [1:0] idx);
        case (idx)
            REG_INPUT_COUNT:  return {26'd0, in_cnt};
            REG_OUTPUT_COUNT: return {27'd0, out_cnt};
            REG_CONN_COUNT:   return {23'd0, conn_cnt};
            default:          return '0;
        endcase
    endfunction

    // Q4.12 value: extremes, small magnitudes and full-range noise.
    function automatic logic signed [15:0] pick_q412();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return 16'($urandom_range(0, 8192)) - 16'sd4096;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_gap();
        if (steady) return 0;
        if ($urandom_range(0, 99) < 38) return $urandom_range(1, 12);
        return 0;
    endfunction

    function automatic t_row reg_row(input logic [1:0] idx, input logic [31:0] data);
        t_row r;
        r.kind      = ROW_REG;
        r.reg_idx   = idx;
        r.reg_data  = data;
        r.cmd       = '0;
        r.typed_n   = -1;
        r.typed_act = '0;
        return r;
    endfunction

    function automatic t_row cmd_row(input logic [1:0] op, input logic [7:0] slot,
                                     input logic [5:0] src, input logic [5:0] dst,
                                     input logic signed [15:0] val,
                                     input int typed_n = -1,
                                     input logic [15:0] typed_act = '0);
        t_row r;
        r.kind      = ROW_CMD;
        r.reg_idx   = '0;
        r.reg_data  = '0;
        r.cmd       = {op, slot, src, dst, val};
        r.typed_n   = typed_n;
        r.typed_act = typed_act;
        return r;
    endfunction

    // Drop start and hold off for a gap of length n.
    task automatic sender_gap(input int n);
        if (n > 0) begin
            if (start_hot) begin
                start <= 1'b0;
                start_hot = 1'b0;
            end
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Present one command, wait for its transfer, then book its outputs.
    task automatic issue(input t_cmd c, input int typed_n, input logic [15:0] typed_act);
        t_res r;
        int   k;
        i_cmd <= c;
        start <= 1'b1;
        start_hot = 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        advance_net(c);
        if (typed_n >= 0) begin
            for (k = 0; k < typed_n; k++) begin
                r.out_index  = 4'(k);
                r.activation = typed_act;
                r.last       = (k == typed_n - 1);
                owed_outputs.push_back(r);
            end
        end else begin
            foreach (tick_out[k]) owed_outputs.push_back(tick_out[k]);
        end
    endtask

    // Stop sending, wait for every owed output, then let a silent tick run out.
    task automatic let_drain();
        if (start_hot) begin
            start <= 1'b0;
            start_hot = 1'b0;
        end
        while (owed_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register, then read it back (except past the end of the map).
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        logic [31:0] seen;
        logic        rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_INPUT_COUNT:  in_cnt   = data[5:0];
            REG_OUTPUT_COUNT: out_cnt  = data[4:0];
            REG_CONN_COUNT:   conn_cnt = data[8:0];
            default: ;
        endcase
        if (idx != REG_SPARE) begin
            // Turn the access straight into the setup of a read.
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge i_clk);
            penable <= 1'b1;
            do begin
                @(negedge i_clk);
                seen = prdata;
                rdy  = pready;
                @(posedge i_clk);
            end while (rdy !== 1'b1);
            if (seen !== reg_value(idx))
                report_mismatch($sformatf("register %0d readback", idx), seen, reg_value(idx));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Check every output transfer against the oldest owed one.
    always @(posedge i_clk) begin : output_check
        t_res want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (owed_outputs.size() == 0) begin
                report_mismatch("output with none owed, out_index", o_res.out_index, -1);
            end else begin
                want = owed_outputs.pop_front();
                if (o_res.out_index !== want.out_index)
                    report_mismatch("out_index", o_res.out_index, want.out_index);
                if (o_res.activation !== want.activation)
                    report_mismatch("activation", o_res.activation, want.activation);
                if (o_res.last !== want.last)
                    report_mismatch("last", o_res.last, want.last);
            end
        end
    end

    // End the run if no transfer of any kind happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start === 1'b1 && busy === 1'b0) || o_strobe === 1'b1 ||
                (psel === 1'b1 && penable === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("sparse_recurrent_net_tick verification failed");
        $finish;
    end

    initial begin : stimulus
        t_row plan [$];
        t_cmd c;
        int   i;
        int   p;
        int   n;
        int   want_in;
        int   want_out;
        int   want_conn;

        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_cmd    <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_cnt   = '0;
        out_cnt  = '0;
        conn_cnt = '0;
        foreach (net_act[i]) begin
            net_act[i] = '0;
            net_sum[i] = '0;
        end

        // Directed part. Links are only walked once their slots have been loaded.
        plan = '{
            // Fresh network: every sum is zero, so every output sits at one half.
            reg_row(REG_OUTPUT_COUNT, 32'd4),
            cmd_row(OP_TICK, 8'd0, 6'd0, 6'd0, 16'sd0, 4, 16'd32768),
            reg_row(REG_INPUT_COUNT, 32'd2),
            reg_row(REG_OUTPUT_COUNT, 32'd2),
            cmd_row(OP_SET_INPUT, 8'd0, 6'd0, 6'd0, 16'sh7FFF),
            cmd_row(OP_SET_INPUT, 8'd0, 6'd1, 6'd0, 16'sh8000),
            // Input ids at or past input_count must be dropped.
            cmd_row(OP_SET_INPUT, 8'd0, 6'd2, 6'd0, 16'sd100),
            cmd_row(OP_SET_INPUT, 8'hFF, 6'd63, 6'd63, -16'sd1),
            cmd_row(OP_LOAD, 8'd0, 6'd0, 6'd2, 16'sh7FFF),
            cmd_row(OP_LOAD, 8'd1, 6'd1, 6'd3, 16'sh8000),
            // Push an input's sum past +8 so the logistic saturates.
            cmd_row(OP_LOAD, 8'd2, 6'd2, 6'd0, 16'sh7FFF),
            cmd_row(OP_LOAD, 8'd255, 6'd63, 6'd63, -16'sd1),
            reg_row(REG_CONN_COUNT, 32'd3),
            cmd_row(OP_TICK, 8'd0, 6'd0, 6'd0, 16'sd0),
            cmd_row(OP_TICK, 8'd0, 6'd0, 6'd0, 16'sd0),
            cmd_row(OP_NONE, 8'hFF, 6'd63, 6'd63, -16'sd1, 0),
            cmd_row(OP_SET_INPUT, 8'd0, 6'd1, 6'd0, 16'sd0),
            // Output ids run past the last neuron; output_count saturates at 16.
            reg_row(REG_INPUT_COUNT, 32'd63),
            reg_row(REG_OUTPUT_COUNT, 32'd31),
            cmd_row(OP_TICK, 8'd0, 6'd0, 6'd0, 16'sd0),
            // No outputs: the tick still advances the network silently.
            reg_row(REG_OUTPUT_COUNT, 32'd0),
            reg_row(REG_INPUT_COUNT, 32'd0),
            cmd_row(OP_TICK, 8'd0, 6'd0, 6'd0, 16'sd0, 0),
            reg_row(REG_INPUT_COUNT, 32'd32),
            reg_row(REG_OUTPUT_COUNT, 32'd16),
            cmd_row(OP_TICK, 8'd0, 6'd0, 6'd0, 16'sd0)
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                let_drain();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end else begin
                issue(plan[i].cmd, plan[i].typed_n, plan[i].typed_act);
                sender_gap(pick_gap());
            end
        end

        // Load every slot so any connection_count is safe to walk; tick now and then.
        for (i = 0; i < LINKS; i++) begin
            c.op         = OP_LOAD;
            c.conn_index = 8'(i);
            c.src_neuron = 6'($urandom_range(0, NEURONS - 1));
            c.dst_neuron = 6'($urandom_range(0, NEURONS - 1));
            c.value      = pick_q412();
            issue(c, -1, '0);
            sender_gap(pick_gap());
            if (i % 64 == 63) begin
                c = {OP_TICK, 8'($urandom), 6'($urandom), 6'($urandom), 16'($urandom)};
                issue(c, -1, '0);
                sender_gap(pick_gap());
            end
        end

        // Random phases, each under its own register setting.
        for (p = 0; p < 7; p++) begin
            let_drain();
            case (p)
                0: begin
                    want_in = 32; want_out = 16; want_conn = 256;
                end
                1: begin
                    want_in = 63; want_out = 31; want_conn = 511;
                end
                2: begin
                    want_in = 0; want_out = 0; want_conn = 0;
                end
                3: begin
                    want_in = 20; want_out = 8; want_conn = 100;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       want_in = 0;
                        1:       want_in = 32;
                        2:       want_in = 63;
                        default: want_in = $urandom_range(1, 32);
                    endcase
                    case ($urandom_range(0, 3))
                        0:       want_out = 0;
                        1:       want_out = 16;
                        2:       want_out = 31;
                        default: want_out = $urandom_range(1, 16);
                    endcase
                    case ($urandom_range(0, 4))
                        0:       want_conn = 0;
                        1:       want_conn = 256;
                        2:       want_conn = 511;
                        3:       want_conn = $urandom_range(0, 256);
                        default: want_conn = $urandom_range(257, 511);
                    endcase
                end
            endcase
            write_reg(REG_INPUT_COUNT, 32'(want_in));
            write_reg(REG_OUTPUT_COUNT, 32'(want_out));
            write_reg(REG_CONN_COUNT, 32'(want_conn));
            write_reg(REG_SPARE, $urandom);
            // One phase runs with no sender gaps at all.
            steady = (p == 3);

            for (n = 0; n < 22; n++) begin
                // Unused fields carry noise on purpose.
                c.conn_index = 8'($urandom);
                c.src_neuron = 6'($urandom);
                c.dst_neuron = 6'($urandom);
                c.value      = pick_q412();
                i = $urandom_range(0, 99);
                if (i < 25) begin
                    c.op = OP_LOAD;
                end else if (i < 60) begin
                    c.op = OP_SET_INPUT;
                    // Mostly hit real input neurons so the sums carry into the tick.
                    if (in_cnt != 0 && $urandom_range(0, 99) < 80)
                        c.src_neuron = 6'($urandom_range(0, int'(in_cnt) - 1));
                end else if (i < 95) begin
                    c.op = OP_TICK;
                end else begin
                    c.op = OP_NONE;
                end
                issue(c, -1, '0);
                sender_gap(pick_gap());
            end
        end
        steady = 1'b0;

        let_drain();
        if (mismatches == 0)
            $display("sparse_recurrent_net_tick verification clean");
        else
            $display("sparse_recurrent_net_tick verification failed");
        $finish;
    end

endmodule
